// ----- hdl/gbs_pkg.sv -----
// Shared constants, types and state codes for the greedy box suppression block.
package gbs_pkg;

	localparam int MAX_KEPT  = 64;
	localparam int IDX_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W     = $clog2(MAX_KEPT + 1);
	localparam int COORD_W   = 13;
	localparam int SIZE_W    = 12;
	localparam int THR_W     = 17;
	localparam int FRAC_W    = 16;
	localparam int AREA_W    = 2 * SIZE_W;
	localparam int UNI_W     = AREA_W + 1;
	localparam int PROD_W    = THR_W + UNI_W;
	localparam int OV_LAT    = 6;
	localparam int DRN_W     = $clog2(OV_LAT);

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_KEPT - 1);
	localparam logic [DRN_W-1:0] DRN_LAST  = DRN_W'(OV_LAT - 1);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_KEPT);

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [SIZE_W-1:0]         width;
		logic [SIZE_W-1:0]         height;
	} box_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} ov_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/gbs_if.sv -----
// Valid/ready channel interfaces for box items and result items.
interface gbs_box_if;
	logic                               valid;
	logic                               ready;
	logic signed [gbs_pkg::COORD_W-1:0] box_left;
	logic signed [gbs_pkg::COORD_W-1:0] box_top;
	logic [gbs_pkg::SIZE_W-1:0]         box_width;
	logic [gbs_pkg::SIZE_W-1:0]         box_height;
	logic                               set_end;

	modport source (
		output valid, box_left, box_top, box_width, box_height, set_end,
		input  ready
	);
	modport sink (
		input  valid, box_left, box_top, box_width, box_height, set_end,
		output ready
	);
endinterface

interface gbs_res_if;
	logic valid;
	logic ready;
	logic keep;
	logic store_full;
	logic result_end;

	modport source (
		output valid, keep, store_full, result_end,
		input  ready
	);
	modport sink (
		input  valid, keep, store_full, result_end,
		output ready
	);
endinterface

// ----- hdl/gbs_cell.sv -----
// One storage cell of the kept-box chain: takes its neighbour's box when shifted.
module gbs_cell (
	input  logic          clk,
	input  logic          shift_en,
	input  gbs_pkg::box_t d,
	output gbs_pkg::box_t q
);

	gbs_pkg::box_t box_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			box_q <= d;
		end
	end

	assign q = box_q;

endmodule

// ----- hdl/gbs_overlap.sv -----
// Pipelined overlap test: intersection*65536 > threshold*union, six stages.
module gbs_overlap (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  gbs_pkg::box_t                a,
	input  gbs_pkg::box_t                b,
	input  logic [gbs_pkg::AREA_W-1:0]   area_b,
	input  logic [gbs_pkg::THR_W-1:0]    thr,
	output gbs_pkg::ov_res_t             res
);

	localparam int CW = gbs_pkg::COORD_W;
	localparam int SW = gbs_pkg::SIZE_W;
	localparam int AW = gbs_pkg::AREA_W;
	localparam int UW = gbs_pkg::UNI_W;
	localparam int PW = gbs_pkg::PROD_W;
	localparam int FW = gbs_pkg::FRAC_W;

	logic signed [CW:0]   ra, rb, ba, bb;
	logic signed [CW-1:0] x1, y1;
	logic signed [CW:0]   x2, y2;
	logic signed [CW+1:0] dx, dy;
	logic [SW-1:0]        iw, ih;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [SW-1:0] iw_s1, ih_s1, wa_s1, ha_s1, wa_s2, ha_s2;
	logic [AW-1:0] inter_s2, inter_s3, inter_s4, inter_s5, area_a_s3;
	logic [UW-1:0] uni_s4;
	logic [PW-1:0] prod_s5;
	logic          nz_s5;
	logic          hit_s6;

	always_comb begin
		ra = $signed({a.left[CW-1], a.left}) + $signed({2'b00, a.width});
		rb = $signed({b.left[CW-1], b.left}) + $signed({2'b00, b.width});
		ba = $signed({a.top[CW-1], a.top}) + $signed({2'b00, a.height});
		bb = $signed({b.top[CW-1], b.top}) + $signed({2'b00, b.height});
		x1 = (a.left > b.left) ? a.left : b.left;
		y1 = (a.top > b.top) ? a.top : b.top;
		x2 = (ra < rb) ? ra : rb;
		y2 = (ba < bb) ? ba : bb;
		dx = $signed({x2[CW], x2}) - $signed({{2{x1[CW-1]}}, x1});
		dy = $signed({y2[CW], y2}) - $signed({{2{y1[CW-1]}}, y1});
		iw = (dx > 0) ? dx[SW-1:0] : '0;
		ih = (dy > 0) ? dy[SW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		iw_s1     <= iw;
		ih_s1     <= ih;
		wa_s1     <= a.width;
		ha_s1     <= a.height;
		inter_s2  <= iw_s1 * ih_s1;
		wa_s2     <= wa_s1;
		ha_s2     <= ha_s1;
		area_a_s3 <= wa_s2 * ha_s2;
		inter_s3  <= inter_s2;
		uni_s4    <= {1'b0, area_a_s3} + {1'b0, area_b} - {1'b0, inter_s3};
		inter_s4  <= inter_s3;
		prod_s5   <= PW'(thr) * PW'(uni_s4);
		nz_s5     <= (uni_s4 != '0);
		inter_s5  <= inter_s4;
		hit_s6    <= nz_s5 && (PW'({inter_s5, {FW{1'b0}}}) > prod_s5);
	end

	assign res.valid = v_s6;
	assign res.hit   = hit_s6;

endmodule

// ----- hdl/greedy_box_suppression.sv -----
// Top level: greedy box suppression over a rotating chain of kept-box cells.
// Each accepted item rotates the whole cell chain through the shared six-stage overlap pipeline;
// a new item is accepted only after the result of the last one has been loaded into the result
// register, so the block works on one item at a time.
// Reset: asynchronous, active low; clears control, count and result valid, threshold 32768.
module greedy_box_suppression (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gbs_pkg::THR_W-1:0]   cfg_wdata,
	gbs_box_if.sink                     box,
	gbs_res_if.source                   result
);

	localparam int N = gbs_pkg::MAX_KEPT;

	gbs_pkg::state_t                 state_q, state_d;
	logic [gbs_pkg::IDX_W-1:0]       idx_q;
	logic [gbs_pkg::DRN_W-1:0]       drn_q;
	logic [gbs_pkg::CNT_W-1:0]       cnt_q;
	logic [gbs_pkg::THR_W-1:0]       thr_q;
	logic [gbs_pkg::AREA_W-1:0]      area_b_q;
	gbs_pkg::box_t                   cur_q;
	logic                            cur_end_q;
	logic                            sup_q;
	logic                            res_valid_q, keep_q, full_q, end_q;

	logic                            accept, issue, load, kept, store_ok, append, shift_en;
	gbs_pkg::box_t                   cell_d [N];
	gbs_pkg::box_t                   cell_q [N];
	gbs_pkg::ov_res_t                ov_res;

	// chain of cells
	assign shift_en  = (state_q == gbs_pkg::ST_SCAN) || append;
	assign cell_d[0] = append ? cur_q : cell_q[N-1];

	for (genvar i = 1; i < N; i++) begin : g_link
		assign cell_d[i] = cell_q[i-1];
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		gbs_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (cell_d[i]),
			.q        (cell_q[i])
		);
	end

	gbs_overlap u_overlap (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (issue),
		.a        (cell_q[N-1]),
		.b        (cur_q),
		.area_b   (area_b_q),
		.thr      (thr_q),
		.res      (ov_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbs_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = gbs_pkg::ST_SCAN;
				end
			end
			gbs_pkg::ST_SCAN: begin
				if (idx_q == gbs_pkg::IDX_LAST) begin
					state_d = gbs_pkg::ST_DRAIN;
				end
			end
			gbs_pkg::ST_DRAIN: begin
				if (drn_q == gbs_pkg::DRN_LAST) begin
					state_d = gbs_pkg::ST_DONE;
				end
			end
			gbs_pkg::ST_DONE: begin
				if (load) begin
					state_d = gbs_pkg::ST_IDLE;
				end
			end
			default: state_d = gbs_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		box.ready = (state_q == gbs_pkg::ST_IDLE);
		accept    = box.valid && box.ready;
		issue     = (state_q == gbs_pkg::ST_SCAN) &&
		            (gbs_pkg::CNT_W'(idx_q) >= (gbs_pkg::CNT_MAX - cnt_q));
		load      = (state_q == gbs_pkg::ST_DONE) && (!res_valid_q || result.ready);
		kept      = !sup_q;
		store_ok  = kept && (cnt_q < gbs_pkg::CNT_MAX);
		append    = load && store_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbs_pkg::ST_IDLE;
			idx_q       <= '0;
			drn_q       <= '0;
			cnt_q       <= '0;
			thr_q       <= gbs_pkg::THR_RESET;
			sup_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (state_q == gbs_pkg::ST_SCAN) begin
				idx_q <= (idx_q == gbs_pkg::IDX_LAST) ? '0 : idx_q + 1'b1;
			end
			if (state_q == gbs_pkg::ST_DRAIN) begin
				drn_q <= (drn_q == gbs_pkg::DRN_LAST) ? '0 : drn_q + 1'b1;
			end
			if (accept) begin
				sup_q <= 1'b0;
			end else if (ov_res.valid && ov_res.hit) begin
				sup_q <= 1'b1;
			end
			if (load) begin
				if (cur_end_q) begin
					cnt_q <= '0;
				end else if (append) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// hold the current box and the result item
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q.left   <= box.box_left;
			cur_q.top    <= box.box_top;
			cur_q.width  <= box.box_width;
			cur_q.height <= box.box_height;
			cur_end_q    <= box.set_end;
			area_b_q     <= box.box_width * box.box_height;
		end
		if (load) begin
			keep_q <= kept;
			full_q <= kept && !store_ok;
			end_q  <= cur_end_q;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.keep       = keep_q;
	assign result.store_full = full_q;
	assign result.result_end = end_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gbs_pkg::CNT_MAX)
		else $error("kept count beyond store depth");

	a_ov_window: assert property (@(posedge clk) disable iff (!arst_n)
		ov_res.valid |-> (state_q == gbs_pkg::ST_SCAN || state_q == gbs_pkg::ST_DRAIN))
		else $error("overlap result outside scan window");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == gbs_pkg::ST_DONE)
		else $error("result item raised outside done state");

	a_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(load && cur_end_q) |=> cnt_q == '0)
		else $error("store not emptied after set end");

	a_append_done: assert property (@(posedge clk) disable iff (!arst_n)
		append |-> (state_q == gbs_pkg::ST_DONE && !sup_q))
		else $error("box stored outside decision");

endmodule
